### rtl/fnvp_pkg.sv
// Shared types and codes for the FastCGI name-value pair parser.
`timescale 1ns / 1ps

package fnvp_pkg;

	localparam int LEN_W = 31;

	typedef enum logic [2:0] {
		PH_NLEN      = 3'd0,
		PH_NLEN_MORE = 3'd1,
		PH_VLEN      = 3'd2,
		PH_VLEN_MORE = 3'd3,
		PH_NAME      = 3'd4,
		PH_VALUE     = 3'd5
	} phase_t;

	localparam logic [1:0] KIND_LEN     = 2'd0;
	localparam logic [1:0] KIND_NAME    = 2'd1;
	localparam logic [1:0] KIND_VALUE   = 2'd2;
	localparam logic [1:0] KIND_DISCARD = 2'd3;

	localparam logic [1:0] LR_NONE  = 2'd0;
	localparam logic [1:0] LR_NAME  = 2'd1;
	localparam logic [1:0] LR_VALUE = 2'd2;

	typedef struct packed {
		phase_t            phase;
		logic [1:0]        idx;
		logic [LEN_W-1:0]  acc;
		logic [LEN_W-1:0]  name_rem;
		logic [LEN_W-1:0]  value_rem;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:     PH_NLEN,
		idx:       2'd0,
		acc:       '0,
		name_rem:  '0,
		value_rem: '0
	};

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        data;
		logic [1:0]        len_ready;
		logic [LEN_W-1:0]  len_value;
		logic              pair_done;
		logic              body_ok;
		logic              parse_error;
	} result_t;

endpackage

### rtl/fnvp_step.sv
// Per-byte parse step: next parser state and the result word for one body byte.
`timescale 1ns / 1ps

module fnvp_step (
	input  fnvp_pkg::state_t  cur,
	input  logic [7:0]        body_byte,
	input  logic              body_last,
	output fnvp_pkg::state_t  nxt,
	output fnvp_pkg::result_t res
);

	fnvp_pkg::phase_t             ph_eff;
	fnvp_pkg::phase_t             ph;
	fnvp_pkg::state_t             st;
	logic                         got_len;
	logic [fnvp_pkg::LEN_W-1:0]   len;
	logic [fnvp_pkg::LEN_W-1:0]   acc_sh;
	logic [fnvp_pkg::LEN_W-1:0]   rem_dec;
	logic [1:0]                   idx_inc;

	// Unused phase codes fall back to expecting a name length.
	always_comb begin
		case (cur.phase)
			fnvp_pkg::PH_NLEN_MORE: ph_eff = fnvp_pkg::PH_NLEN_MORE;
			fnvp_pkg::PH_VLEN:      ph_eff = fnvp_pkg::PH_VLEN;
			fnvp_pkg::PH_VLEN_MORE: ph_eff = fnvp_pkg::PH_VLEN_MORE;
			fnvp_pkg::PH_NAME:      ph_eff = fnvp_pkg::PH_NAME;
			fnvp_pkg::PH_VALUE:     ph_eff = fnvp_pkg::PH_VALUE;
			default:                ph_eff = fnvp_pkg::PH_NLEN;
		endcase
	end

	assign acc_sh  = {cur.acc[fnvp_pkg::LEN_W-9:0], body_byte};
	assign idx_inc = cur.idx + 2'd1;

	always_comb begin
		st            = cur;
		ph            = ph_eff;
		got_len       = 1'b0;
		len           = '0;
		rem_dec       = '0;
		res.kind      = fnvp_pkg::KIND_LEN;
		res.data      = body_byte;
		res.len_ready = fnvp_pkg::LR_NONE;
		res.len_value = '0;
		res.pair_done = 1'b0;
		res.body_ok   = 1'b0;
		res.parse_error = 1'b0;

		case (ph_eff)
			fnvp_pkg::PH_NLEN, fnvp_pkg::PH_VLEN: begin
				if (!body_byte[7]) begin
					got_len = 1'b1;
					len     = {{(fnvp_pkg::LEN_W-8){1'b0}}, body_byte};
				end else begin
					st.acc = {{(fnvp_pkg::LEN_W-7){1'b0}}, body_byte[6:0]};
					st.idx = 2'd1;
					ph = (ph_eff == fnvp_pkg::PH_NLEN) ? fnvp_pkg::PH_NLEN_MORE
						: fnvp_pkg::PH_VLEN_MORE;
				end
			end
			fnvp_pkg::PH_NLEN_MORE, fnvp_pkg::PH_VLEN_MORE: begin
				st.acc = acc_sh;
				st.idx = idx_inc;
				if (idx_inc == 2'd0) begin
					got_len = 1'b1;
					len     = acc_sh;
					st.acc  = '0;
					ph = (ph_eff == fnvp_pkg::PH_NLEN_MORE) ? fnvp_pkg::PH_NLEN
						: fnvp_pkg::PH_VLEN;
				end
			end
			fnvp_pkg::PH_NAME: begin
				res.kind    = fnvp_pkg::KIND_NAME;
				rem_dec     = cur.name_rem - {{(fnvp_pkg::LEN_W-1){1'b0}}, 1'b1};
				st.name_rem = rem_dec;
				if (rem_dec == '0) begin
					if (cur.value_rem != '0) begin
						ph = fnvp_pkg::PH_VALUE;
					end else begin
						res.pair_done = 1'b1;
						ph = fnvp_pkg::PH_NLEN;
					end
				end
			end
			fnvp_pkg::PH_VALUE: begin
				res.kind     = fnvp_pkg::KIND_VALUE;
				rem_dec      = cur.value_rem - {{(fnvp_pkg::LEN_W-1){1'b0}}, 1'b1};
				st.value_rem = rem_dec;
				if (rem_dec == '0) begin
					res.pair_done = 1'b1;
					ph = fnvp_pkg::PH_NLEN;
				end
			end
			default: begin
				res.kind = fnvp_pkg::KIND_LEN;
			end
		endcase

		if (got_len) begin
			res.len_value = len;
			if (ph == fnvp_pkg::PH_NLEN) begin
				res.len_ready = fnvp_pkg::LR_NAME;
				st.name_rem   = len;
				ph = fnvp_pkg::PH_VLEN;
			end else begin
				res.len_ready = fnvp_pkg::LR_VALUE;
				st.value_rem  = len;
				// skip empty parts; both empty closes the pair here
				if (st.name_rem != '0) begin
					ph = fnvp_pkg::PH_NAME;
				end else if (len != '0) begin
					ph = fnvp_pkg::PH_VALUE;
				end else begin
					res.pair_done = 1'b1;
					ph = fnvp_pkg::PH_NLEN;
				end
			end
		end

		st.phase = ph;

		if (body_last) begin
			res.body_ok     = (ph == fnvp_pkg::PH_NLEN);
			res.parse_error = (ph != fnvp_pkg::PH_NLEN);
			st = fnvp_pkg::STATE_RESET;
		end

		nxt = st;
	end

endmodule

### rtl/fnvp_out_reg.sv
// Output register that holds one result word until the consumer takes it.
`timescale 1ns / 1ps

module fnvp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fnvp_pkg::result_t res_d,
	input  logic              out_ready,
	output logic              out_valid,
	output fnvp_pkg::result_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;

endmodule

### rtl/fcgi_name_value_pair_parser.sv
// Top level of the FastCGI name-value pair parser.
// Result: each accepted body byte's result word is registered and shows on the output in the next cycle.
// Throughput: one byte per cycle; the single parse step between the state register
// and the output register sets that figure, and a byte is taken while a result waits
// as long as the consumer takes that result in the same cycle.
// Reset: arst_n clears the parser state and the output valid; payload is not reset.
`timescale 1ns / 1ps

module fcgi_name_value_pair_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  body_byte,
	input  logic        body_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  byte_kind,
	output logic [7:0]  byte_out,
	output logic [1:0]  length_ready,
	output logic [30:0] length_value,
	output logic        pair_done,
	output logic        body_ok,
	output logic        parse_error
);

	fnvp_pkg::state_t  state_q;
	fnvp_pkg::state_t  state_d;
	fnvp_pkg::result_t res_d;
	fnvp_pkg::result_t res_q;
	logic              accept;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	fnvp_step u_step (
		.cur       (state_q),
		.body_byte (body_byte),
		.body_last (body_last),
		.nxt       (state_d),
		.res       (res_d)
	);

	// advance the parser only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnvp_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	fnvp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign byte_kind    = res_q.kind;
	assign byte_out     = res_q.data;
	assign length_ready = res_q.len_ready;
	assign length_value = res_q.len_value;
	assign pair_done    = res_q.pair_done;
	assign body_ok      = res_q.body_ok;
	assign parse_error  = res_q.parse_error;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no result");

	a_last_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && body_last) |=> (state_q == fnvp_pkg::STATE_RESET))
		else $error("parser state not cleared after last byte");

	a_name_phase_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && state_q.phase == fnvp_pkg::PH_NAME)
			|=> (byte_kind == fnvp_pkg::KIND_NAME))
		else $error("byte in name phase not tagged as name");

	a_last_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && body_last) |=> (body_ok != parse_error))
		else $error("last byte without exactly one verdict");

endmodule
